// ----- rtl/ist_pkg.sv -----
// shared types and constants of the id set table
package ist_pkg;

	localparam int TAG_W = 32;
	localparam int POS_W = 6;
	localparam int CNT_W = 7;
	localparam int MAX_W = 7;
	localparam logic [MAX_W-1:0] MAX_RESET = 7'd64;

	// command queue between the front and the back
	localparam int QDEPTH = 2;
	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_CONTAINS = 2'd2,
		OP_GET      = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             search;
		logic [TAG_W-1:0] tag_id;
		logic [POS_W-1:0] position;
	} cmd_t;

endpackage

// ----- rtl/ist_if.sv -----
// request and response channel interfaces of the id set table
interface ist_req_if import ist_pkg::*; ();
	logic             valid;
	logic             ready;
	op_t              op;
	logic [TAG_W-1:0] tag_id;
	logic [POS_W-1:0] position;

	modport source (output valid, output op, output tag_id, output position, input ready);
	modport sink (input valid, input op, input tag_id, input position, output ready);
endinterface

interface ist_rsp_if import ist_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             ok;
	logic [POS_W-1:0] found_position;
	logic [TAG_W-1:0] read_id;
	logic [CNT_W-1:0] entry_count;

	modport source (output valid, output ok, output found_position, output read_id,
		output entry_count, input ready);
	modport sink (input valid, input ok, input found_position, input read_id,
		input entry_count, output ready);
endinterface

// ----- rtl/ist_front.sv -----
// front end: accepts request words, classifies them and queues commands
module ist_front import ist_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ist_req_if.sink   req,
	output cmd_t      cmd,
	output logic      cmd_valid,
	input  logic      cmd_ready
);

	cmd_t             queue_q [QDEPTH];
	logic [QAW-1:0]   wptr_q;
	logic [QAW-1:0]   rptr_q;
	logic [QCW-1:0]   fill_q;
	logic             push;
	logic             pop;
	cmd_t             cmd_in;

	assign req.ready = (fill_q != QCW'(QDEPTH));
	assign cmd_valid = (fill_q != '0);
	assign push      = req.valid && req.ready;
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = queue_q[rptr_q];

	// get reads by position, every other op searches the table
	always_comb begin
		cmd_in.op       = req.op;
		cmd_in.search   = (req.op != OP_GET);
		cmd_in.tag_id   = req.tag_id;
		cmd_in.position = req.position;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QAW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QAW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/ist_back.sv -----
// back end: entry memory, linear scan, swap-remove and the result register
module ist_back import ist_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [MAX_W-1:0] cfg_wdata,
	input  cmd_t             cmd,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	ist_rsp_if.source        rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > MAX_W) ? CW : MAX_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RM_RD,
		ST_RM_WR,
		ST_GET_RD,
		ST_GET_WAIT
	} state_t;

	logic [TAG_W-1:0] mem [CAPACITY];
	logic [TAG_W-1:0] rd_data_q;
	logic [AW-1:0]    rd_addr;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [TAG_W-1:0] mem_wdata;

	state_t           state_q;
	cmd_t             cur_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    idx_q;
	logic             vld_s1;
	logic [AW-1:0]    addr_s1;
	logic [AW-1:0]    where_q;
	logic [MAX_W-1:0] max_q;

	logic             out_valid_q;
	logic             ok_q;
	logic [POS_W-1:0] pos_q;
	logic [TAG_W-1:0] rid_q;
	logic [CNT_W-1:0] count_q;

	logic             out_free;
	logic             issue;
	logic             hit;
	logic             miss;
	logic             room;
	logic             pos_ok;
	logic             fin;
	logic             f_ok;
	logic [AW-1:0]    f_pos;
	logic [TAG_W-1:0] f_rd;
	logic [CW-1:0]    f_cnt;

	assign out_free  = !out_valid_q || rsp.ready;
	assign cmd_ready = (state_q == ST_IDLE) && out_free;

	assign rsp.valid          = out_valid_q;
	assign rsp.ok             = ok_q;
	assign rsp.found_position = pos_q;
	assign rsp.read_id        = rid_q;
	assign rsp.entry_count    = count_q;

	// the scan issues one address a cycle and compares the read data in the cycle after
	assign issue  = (state_q == ST_SCAN) && (idx_q < cnt_q);
	assign hit    = (state_q == ST_SCAN) && vld_s1 && (rd_data_q == cur_q.tag_id);
	assign miss   = (state_q == ST_SCAN) && !vld_s1 && !issue;
	assign room   = (XW'(cnt_q) < XW'(max_q)) && (cnt_q < CW'(CAPACITY));
	assign pos_ok = XW'(cur_q.position) < XW'(cnt_q);

	always_comb begin
		case (state_q)
			ST_SCAN:   rd_addr = AW'(idx_q);
			ST_RM_RD:  rd_addr = AW'(cnt_q - 1'b1);
			ST_GET_RD: rd_addr = AW'(cur_q.position);
			default:   rd_addr = '0;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(cnt_q);
		mem_wdata = cur_q.tag_id;
		if (miss && cur_q.op == OP_INSERT && room) begin
			mem_we = 1'b1;
		end else if (state_q == ST_RM_WR) begin
			// last entry moves into the freed slot
			mem_we    = 1'b1;
			mem_waddr = where_q;
			mem_wdata = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_comb begin
		fin   = 1'b0;
		f_ok  = 1'b0;
		f_pos = '0;
		f_rd  = '0;
		f_cnt = cnt_q;
		case (state_q)
			ST_SCAN: begin
				if (hit) begin
					if (cur_q.op != OP_REMOVE) begin
						fin   = 1'b1;
						f_ok  = 1'b1;
						f_pos = addr_s1;
					end
				end else if (miss) begin
					fin = 1'b1;
					if (cur_q.op == OP_INSERT && room) begin
						f_ok  = 1'b1;
						f_cnt = cnt_q + 1'b1;
					end
				end
			end
			ST_RM_WR: begin
				fin   = 1'b1;
				f_ok  = 1'b1;
				f_pos = where_q;
				f_cnt = cnt_q - 1'b1;
			end
			ST_GET_RD: begin
				fin = !pos_ok;
			end
			ST_GET_WAIT: begin
				fin  = 1'b1;
				f_ok = 1'b1;
				f_rd = rd_data_q;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			addr_s1     <= '0;
			where_q     <= '0;
			max_q       <= MAX_RESET;
			out_valid_q <= 1'b0;
			ok_q        <= 1'b0;
			pos_q       <= '0;
			rid_q       <= '0;
			count_q     <= '0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_valid && out_free) begin
						cur_q   <= cmd;
						idx_q   <= '0;
						vld_s1  <= 1'b0;
						state_q <= cmd.search ? ST_SCAN : ST_GET_RD;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					vld_s1  <= issue;
					addr_s1 <= AW'(idx_q);
					if (hit && cur_q.op == OP_REMOVE) begin
						where_q <= addr_s1;
						state_q <= ST_RM_RD;
					end else if (fin) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RM_RD: begin
					state_q <= ST_RM_WR;
				end
				ST_RM_WR: begin
					state_q <= ST_IDLE;
				end
				ST_GET_RD: begin
					state_q <= pos_ok ? ST_GET_WAIT : ST_IDLE;
				end
				ST_GET_WAIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (fin) begin
				cnt_q       <= f_cnt;
				out_valid_q <= 1'b1;
				ok_q        <= f_ok;
				pos_q       <= POS_W'(f_pos);
				rid_q       <= f_rd;
				count_q     <= CNT_W'(f_cnt);
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_fin_empty: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !out_valid_q)
		else $error("result finished while result register still full");

	a_rm_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RM_WR) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("remove did not decrement the count");

	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= cnt_q))
		else $error("scan index ran past the live entries");

endmodule

// ----- rtl/id_set_table.sv -----
// top level of the id set table
// Holds a set of distinct 32-bit tag ids in a CAPACITY-entry memory with one read and one
// write port. Request words are queued by the front end (two deep) and carried out one at a
// time by the back end. Insert, remove and contains scan the live entries one per cycle; a
// successful remove then fetches the last entry and writes it into the freed slot. Get reads
// the entry at the given position and skips the read when the position is at or past the
// count. The back end starts the next word only once the result register is free, so a
// stalled result holds the queue. The entry memory has no reset; the count, the max_entries
// limit (reset 64) and the control and result registers are cleared. Write max_entries
// only while the block is idle.
module id_set_table import ist_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	ist_req_if.sink          req,
	ist_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  logic [MAX_W-1:0] cfg_wdata
);

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	ist_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	ist_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp       (rsp)
	);

endmodule

// ----- tb/id_set_table_test.sv -----
// self-checking testbench of the id set table: directed and random words against a mirror
`timescale 1ns / 1ps

module id_set_table_test import ist_pkg::*; ();

	localparam int CAPACITY = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int POOL_SIZE = 96;

	typedef struct packed {
		logic             ok;
		logic [POS_W-1:0] where;
		logic [TAG_W-1:0] read_id;
		logic [CNT_W-1:0] count;
	} answer_t;

	// mirror of the table plus the answers still owed by the block
	class table_scoreboard;
		logic [TAG_W-1:0] ids [CAPACITY];
		int unsigned      held;
		int unsigned      limit;
		answer_t          due_answers [$];
		int unsigned      mismatches;

		function new();
			held = 0;
			limit = MAX_RESET;
			mismatches = 0;
		endfunction

		function void set_limit(logic [MAX_W-1:0] value);
			limit = (value < CAPACITY) ? value : CAPACITY;
		endfunction

		function int pending();
			return due_answers.size();
		endfunction

		function bit lookup(logic [TAG_W-1:0] tag, output int unsigned at);
			int unsigned i;
			at = 0;
			for (i = 0; i < held; i++) begin
				if (ids[i] == tag) begin
					at = i;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_request(op_t op, logic [TAG_W-1:0] tag, logic [POS_W-1:0] pos);
			answer_t     a;
			int unsigned at;
			bit          hit;
			a = '0;
			case (op)
				OP_INSERT: begin
					hit = lookup(tag, at);
					if (hit) begin
						a.ok = 1'b1;
						a.where = POS_W'(at);
					end else if (held < limit) begin
						ids[held] = tag;
						held++;
						a.ok = 1'b1;
					end
				end
				OP_REMOVE: begin
					hit = lookup(tag, at);
					if (hit) begin
						// last entry fills the hole
						ids[at] = ids[held - 1];
						held--;
						a.ok = 1'b1;
						a.where = POS_W'(at);
					end
				end
				OP_CONTAINS: begin
					hit = lookup(tag, at);
					a.ok = hit;
					a.where = POS_W'(at);
				end
				default: begin
					if (pos < held) begin
						a.ok = 1'b1;
						a.read_id = ids[pos];
					end
				end
			endcase
			a.count = CNT_W'(held);
			due_answers.push_back(a);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_answer(logic ok, logic [POS_W-1:0] where, logic [TAG_W-1:0] read_id,
				logic [CNT_W-1:0] count);
			answer_t a;
			if (due_answers.size() == 0) begin
				$error("answer word with none expected: ok %0d count %0d", ok, count);
				mismatches++;
				return;
			end
			a = due_answers.pop_front();
			compare_field("ok", 32'(a.ok), 32'(ok));
			compare_field("found_position", 32'(a.where), 32'(where));
			compare_field("read_id", a.read_id, read_id);
			compare_field("entry_count", 32'(a.count), 32'(count));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [MAX_W-1:0] cfg_wdata;

	ist_req_if req ();
	ist_rsp_if rsp ();

	id_set_table #(.CAPACITY(CAPACITY)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	table_scoreboard  sb;
	logic [TAG_W-1:0] tag_pool [POOL_SIZE];
	int unsigned      answers_taken = 0;
	int unsigned      gap_pct = 0;
	int unsigned      stall_pct = 0;
	bit               calm = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// answer checked before the request is noted so a stray answer is never matched to it
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				sb.check_answer(rsp.ok, rsp.found_position, rsp.read_id, rsp.entry_count);
				answers_taken++;
			end
			if (req.valid && req.ready)
				sb.note_request(req.op, req.tag_id, req.position);
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("id_set_table regression: fail");
		$finish;
	end

	// response side: random stalls plus one long hold-off to back the block up
	initial begin : receiver
		int unsigned stall_left;
		bit          held_off;
		stall_left = 0;
		held_off = 1'b0;
		rsp.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && answers_taken >= 150) begin
				held_off = 1'b1;
				stall_left = HOLD_CYCLES - 1;
				rsp.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (!calm && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(1, 6) - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	task automatic send_request(op_t op, logic [TAG_W-1:0] tag, logic [POS_W-1:0] pos);
		int unsigned gap;
		if (!calm && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.op <= op;
		req.tag_id <= tag;
		req.position <= pos;
		do
			@(posedge clk);
		while (!req.ready);
	endtask

	// drop valid and wait for every owed answer
	task automatic settle();
		@(negedge clk);
		req.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_limit(logic [MAX_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(value);
	endtask

	// mostly ids already held or from a small pool so that hits are common
	function automatic logic [TAG_W-1:0] pick_tag();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50 && sb.held > 0)
			return sb.ids[$urandom_range(0, sb.held - 1)];
		else if (r < 85)
			return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	task automatic run_phase(logic [MAX_W-1:0] limit, int unsigned words,
			int unsigned insert_w, int unsigned remove_w, int unsigned gaps, int unsigned stalls);
		int unsigned      n;
		int unsigned      r;
		op_t              op;
		logic [POS_W-1:0] pos;
		settle();
		write_limit(limit);
		gap_pct = gaps;
		stall_pct = stalls;
		for (n = 0; n < words; n++) begin
			r = $urandom_range(0, 99);
			if (r < insert_w)
				op = OP_INSERT;
			else if (r < insert_w + remove_w)
				op = OP_REMOVE;
			else if (r < insert_w + remove_w + (100 - insert_w - remove_w) / 2)
				op = OP_CONTAINS;
			else
				op = OP_GET;
			if ($urandom_range(0, 3) == 0)
				pos = POS_W'($urandom_range(0, 63));
			else
				pos = POS_W'($urandom_range(0, (sb.held < 63) ? sb.held : 63));
			send_request(op, pick_tag(), pos);
		end
	endtask

	initial begin : stimulus
		int unsigned i;
		req.valid = 1'b0;
		req.op = OP_INSERT;
		req.tag_id = '0;
		req.position = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		sb = new();
		tag_pool[0] = 32'h0000_0000;
		tag_pool[1] = 32'hFFFF_FFFF;
		for (i = 2; i < POOL_SIZE; i++)
			tag_pool[i] = $urandom;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// empty table
		send_request(OP_GET, 32'h0, 6'd0);
		send_request(OP_REMOVE, 32'h5, 6'd0);
		send_request(OP_CONTAINS, 32'h0, 6'd0);
		// extreme ids, duplicate insert, get past the count, removal of the last entry
		send_request(OP_INSERT, 32'h0, 6'd0);
		send_request(OP_INSERT, 32'hFFFF_FFFF, 6'd63);
		send_request(OP_INSERT, 32'h0, 6'd0);
		send_request(OP_CONTAINS, 32'hFFFF_FFFF, 6'd0);
		send_request(OP_GET, 32'h0, 6'd1);
		send_request(OP_GET, 32'h0, 6'd63);
		send_request(OP_REMOVE, 32'h1234, 6'd0);
		send_request(OP_REMOVE, 32'hFFFF_FFFF, 6'd0);
		send_request(OP_REMOVE, 32'h0, 6'd0);
		// full table: new id refused, present id still accepted
		settle();
		write_limit(7'd2);
		send_request(OP_INSERT, 32'hA5A5_0001, 6'd0);
		send_request(OP_INSERT, 32'h5A5A_0002, 6'd0);
		send_request(OP_INSERT, 32'h0000_0003, 6'd0);
		send_request(OP_INSERT, 32'h5A5A_0002, 6'd0);
		// limit below the count: held ids stay, new ones refused until the count drops below the limit
		settle();
		write_limit(7'd1);
		send_request(OP_INSERT, 32'h0000_0003, 6'd0);
		send_request(OP_CONTAINS, 32'h5A5A_0002, 6'd0);
		send_request(OP_REMOVE, 32'hA5A5_0001, 6'd0);
		send_request(OP_GET, 32'h0, 6'd0);
		send_request(OP_INSERT, 32'h0000_0003, 6'd0);
		send_request(OP_REMOVE, 32'h5A5A_0002, 6'd0);
		send_request(OP_INSERT, 32'h0000_0003, 6'd0);
		settle();
		write_limit(7'd0);
		send_request(OP_INSERT, 32'hA5A5_0001, 6'd0);
		send_request(OP_GET, 32'h0, 6'd0);
		send_request(OP_REMOVE, 32'h0000_0003, 6'd0);

		run_phase(7'd64, 260, 60, 15, 20, 20);
		run_phase(7'd32, 240, 40, 30, 0, 0);
		run_phase(7'd1, 200, 45, 25, 40, 10);
		run_phase(7'd0, 150, 40, 30, 10, 40);
		run_phase(7'd63, 260, 60, 15, 15, 15);
		run_phase(MAX_W'($urandom_range(2, 62)), 240, 45, 35, 30, 0);
		run_phase(7'd64, 280, 65, 10, 0, 30);
		calm = 1'b1;
		run_phase(7'd64, 300, 45, 35, 0, 0);

		@(negedge clk);
		req.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("id_set_table regression: pass");
		else
			$display("id_set_table regression: fail");
		$finish;
	end

endmodule
